// File: src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and codes of the double-ended queue unit
// ----------------------------------------------------------------------------
package deq_pkg;

	// operation codes carried in the input tuser
	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_CLEAR      = 3'd4
	} op_t;

	// result status codes carried in the output tuser
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// what the back end does with the slot store
	typedef enum logic [1:0] {
		K_NONE  = 2'd0,
		K_WRITE = 2'd1,
		K_READ  = 2'd2
	} kind_t;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OCC_W  = 5;

	localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

	// command from the front end to the back end (slot address travels apart)
	typedef struct packed {
		kind_t                    kind;
		status_t                  status;
		logic [OCC_W-1:0]         occupancy;
		logic signed [WORD_W-1:0] word;
	} cmd_t;

	localparam int unsigned CMD_W = $bits(cmd_t);

endpackage

// File: src/deq_front.sv
// ----------------------------------------------------------------------------
// deq_front
// accepts operations, keeps front index and count, issues slot commands
// ----------------------------------------------------------------------------
module deq_front import deq_pkg::*; #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned AW       = $clog2(CAPACITY)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               op,
	input  logic signed [WORD_W-1:0] item,
	output logic                     cmd_valid,
	input  logic                     cmd_ready,
	output cmd_t                     cmd,
	output logic [AW-1:0]            cmd_addr
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned SW = AW + 1;

	logic [AW-1:0] fi_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] fi_d;
	logic [CW-1:0] cnt_d;
	logic [AW-1:0] fi_dec;
	logic [AW-1:0] fi_inc;
	logic [SW-1:0] back_sum;
	logic [SW-1:0] back_last_sum;
	logic [SW-1:0] back_pos;
	logic [SW-1:0] last_pos;
	logic          full;
	logic          empty;
	logic          accept;

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign accept    = in_valid && cmd_ready;

	assign full  = (cnt_q == CW'(CAPACITY));
	assign empty = (cnt_q == '0);

	assign fi_dec = (fi_q == '0) ? AW'(CAPACITY - 1) : fi_q - AW'(1);
	assign fi_inc = (fi_q == AW'(CAPACITY - 1)) ? '0 : fi_q + AW'(1);

	// slot past the back and the back slot itself, wrapped once
	assign back_sum      = {1'b0, fi_q} + SW'(cnt_q);
	assign back_last_sum = back_sum - SW'(1);
	assign back_pos      = (back_sum >= SW'(CAPACITY)) ? back_sum - SW'(CAPACITY) : back_sum;
	assign last_pos      = (back_last_sum >= SW'(CAPACITY)) ?
		back_last_sum - SW'(CAPACITY) : back_last_sum;

	always_comb begin
		fi_d          = fi_q;
		cnt_d         = cnt_q;
		cmd_addr      = fi_q;
		cmd.kind      = K_NONE;
		cmd.status    = ST_DONE;
		cmd.word      = item;
		case (op)
			OP_PUSH_FRONT: begin
				if (full) begin
					cmd.status = ST_FULL;
				end else begin
					fi_d     = fi_dec;
					cnt_d    = cnt_q + CW'(1);
					cmd_addr = fi_dec;
					cmd.kind = K_WRITE;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					cmd.status = ST_FULL;
				end else begin
					cnt_d    = cnt_q + CW'(1);
					cmd_addr = back_pos[AW-1:0];
					cmd.kind = K_WRITE;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					fi_d     = fi_inc;
					cnt_d    = cnt_q - CW'(1);
					cmd.kind = K_READ;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cnt_d    = cnt_q - CW'(1);
					cmd_addr = last_pos[AW-1:0];
					cmd.kind = K_READ;
				end
			end
			OP_CLEAR: begin
				fi_d  = '0;
				cnt_d = '0;
			end
			default: begin
			end
		endcase
		cmd.occupancy = OCC_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi_q  <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			fi_q  <= fi_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// File: src/deq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// deq_cmd_fifo
// two-entry command queue between front end and back end
// ----------------------------------------------------------------------------
module deq_cmd_fifo #(
	parameter int unsigned WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             push;
	logic             pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_data  = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= in_data;
	end

endmodule

// File: src/deq_back.sv
// ----------------------------------------------------------------------------
// deq_back
// slot store and result register; carries out writes and reads in order
// ----------------------------------------------------------------------------
module deq_back import deq_pkg::*; #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned AW       = $clog2(CAPACITY)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  cmd_t                     cmd,
	input  logic [AW-1:0]            cmd_addr,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic signed [WORD_W-1:0] res_value,
	output status_t                  res_status,
	output logic [OCC_W-1:0]         res_occupancy
);

	logic signed [WORD_W-1:0] slots [CAPACITY];
	logic signed [WORD_W-1:0] rd_q;
	logic                     valid_q;
	cmd_t                     meta_q;
	logic                     take;

	assign cmd_ready = !valid_q || res_ready;
	assign take      = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			meta_q <= cmd;
			if (cmd.kind == K_WRITE) slots[cmd_addr] <= cmd.word;
			if (cmd.kind == K_READ) rd_q <= slots[cmd_addr];
		end
	end

	assign res_valid     = valid_q;
	assign res_status    = meta_q.status;
	assign res_occupancy = meta_q.occupancy;
	assign res_value     = (meta_q.kind == K_READ) ? rd_q :
		(meta_q.status == ST_EMPTY) ? EMPTY_WORD : '0;

endmodule

// File: src/double_ended_queue_unit.sv
// an accepted word is registered in the command queue, then in the result register
// throughput: one op per cycle unless results back up; set by the single slot store port
// a two-entry command queue lets the front end keep accepting while a result waits
// reset: front index and count clear at once, queue empty; slot contents are not cleared
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded double-ended queue of signed words in a circular slot store
// ----------------------------------------------------------------------------
module double_ended_queue_unit import deq_pkg::*; #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// operation stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // item[31:0]
	input  logic [2:0]  s_axis_tuser,   // operation[2:0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // popped_value[31:0], occupancy[36:32], zero pad
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned QW = CMD_W + AW;

	// front end to command queue
	logic          f_valid;
	logic          f_ready;
	cmd_t          f_cmd;
	logic [AW-1:0] f_addr;

	// command queue to back end
	logic          b_valid;
	logic          b_ready;
	logic [QW-1:0] b_data;
	cmd_t          b_cmd;
	logic [AW-1:0] b_addr;

	// result side
	logic signed [WORD_W-1:0] r_value;
	status_t                  r_status;
	logic [OCC_W-1:0]         r_occupancy;

	// decode the operation and move the indices
	deq_front #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.op        (s_axis_tuser),
		.item      (s_axis_tdata),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd),
		.cmd_addr  (f_addr)
	);

	// decouples the index bookkeeping from the slot store
	deq_cmd_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_cmd, f_addr}),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data)
	);

	assign b_cmd  = b_data[QW-1:AW];
	assign b_addr = b_data[AW-1:0];

	// slot store access and the result register
	deq_back #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (b_valid),
		.cmd_ready     (b_ready),
		.cmd           (b_cmd),
		.cmd_addr      (b_addr),
		.res_valid     (m_axis_tvalid),
		.res_ready     (m_axis_tready),
		.res_value     (r_value),
		.res_status    (r_status),
		.res_occupancy (r_occupancy)
	);

	// pack the result word, value in the low bits
	assign m_axis_tdata = {3'b000, r_occupancy, r_value};
	assign m_axis_tuser = r_status;

`ifndef ASSERT_OFF
	// a pop on an empty queue reports all ones and nothing stored
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
			(m_axis_tdata[31:0] == 32'hFFFF_FFFF) && (m_axis_tdata[36:32] == 5'd0))
		else $error("empty pop result malformed");

	// a dropped push only happens at full occupancy and returns zero
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
			(m_axis_tdata[36:32] == OCC_W'(CAPACITY)) && (m_axis_tdata[31:0] == 32'd0))
		else $error("dropped push result malformed");

	// reported occupancy never exceeds capacity while it fits the field
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (CAPACITY < 32) |-> (m_axis_tdata[36:32] <= OCC_W'(CAPACITY)))
		else $error("occupancy above capacity");
`endif

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the double-ended queue unit
//
// operations go in on the slave stream with random gaps and come back as
// results on the master stream under random back-pressure. a queue model in
// the bench tracks the front index, the count and the stored words. it works
// out the popped word, status and occupancy of every accepted operation.
// results are compared in order, field by field. directed tests cover empty
// and full edges, and a long random run walks the occupancy up and down.
// ----------------------------------------------------------------------------
module tb_top;
	import deq_pkg::*;

	localparam int unsigned CAPACITY = 16;

	// operation codes the unit treats as no-ops
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	// how a random stretch leans between pushes and pops
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		status_t                  status;
		logic [OCC_W-1:0]         occupancy;
	} deq_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	// bench copy of the queue
	logic signed [WORD_W-1:0] queue_slots [CAPACITY];
	int unsigned              queue_front = 0;
	int unsigned              queue_count = 0;

	deq_result_t pending_results [$];
	int          fail_count = 0;
	bit          no_idle = 1'b0;

	double_ended_queue_unit #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// run one operation through the bench queue and record the result it gives
	task automatic apply_deque_op(input logic [2:0] op, input logic signed [WORD_W-1:0] word);
		deq_result_t res;
		int unsigned pos;
		res.value = '0;
		res.status = ST_DONE;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (queue_count >= CAPACITY) begin
					// word is dropped, nothing moves
					res.status = ST_FULL;
				end else if (op == OP_PUSH_FRONT) begin
					queue_front = (queue_front + CAPACITY - 1) % CAPACITY;
					queue_slots[queue_front] = word;
					queue_count++;
				end else begin
					pos = (queue_front + queue_count) % CAPACITY;
					queue_slots[pos] = word;
					queue_count++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (queue_count == 0) begin
					res.value = EMPTY_WORD;
					res.status = ST_EMPTY;
				end else if (op == OP_POP_FRONT) begin
					res.value = queue_slots[queue_front];
					queue_front = (queue_front + 1) % CAPACITY;
					queue_count--;
				end else begin
					pos = (queue_front + queue_count - 1) % CAPACITY;
					res.value = queue_slots[pos];
					queue_count--;
				end
			end
			OP_CLEAR: begin
				queue_front = 0;
				queue_count = 0;
			end
			default: begin
				// spare codes leave everything alone
			end
		endcase
		res.occupancy = queue_count[OCC_W-1:0];
		pending_results.push_back(res);
	endtask

	// offer one word on the slave side after a random gap, wait for it to be taken
	task automatic send_op(input logic [2:0] op, input logic signed [WORD_W-1:0] word);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		apply_deque_op(op, word);
	endtask

	// hold off the sender until every result is back
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// pops and a spare code on an empty queue, clear with nothing stored
	task automatic test_empty_queue();
		send_op(OP_POP_FRONT, WORD_MAX);
		send_op(OP_POP_BACK, WORD_MIN);
		send_op(OP_CLEAR, '1);
		send_op(OP_SPARE_FIRST, '0);
	endtask

	// fill from both ends with edge values, overflow at both ends, pop both ends
	task automatic test_full_queue();
		logic signed [WORD_W-1:0] word;
		for (int i = 0; i < CAPACITY; i++) begin
			case (i % 6)
				0: word = WORD_MIN;
				1: word = WORD_MAX;
				2: word = '1;
				3: word = '0;
				default: word = $urandom;
			endcase
			send_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, word);
		end
		send_op(OP_PUSH_FRONT, 32'sh5555_5555);
		send_op(OP_PUSH_BACK, 32'sh2aaa_aaaa);
		send_op(OP_POP_FRONT, '0);
		send_op(OP_POP_BACK, '0);
		wait_for_results();
	endtask

	// stretches that lean toward filling, draining or neither, with clears,
	// spare codes and occasional full stops of the sender
	task automatic test_random_traffic(input int num_ops);
		int   sent;
		int   stretch;
		int   push_pct;
		int   roll;
		mix_t mix;
		logic [2:0]               op;
		logic signed [WORD_W-1:0] word;
		sent = 0;
		while (sent < num_ops) begin
			stretch = $urandom_range(10, 40);
			mix = mix_t'($urandom_range(0, 2));
			no_idle = ($urandom_range(0, 3) == 0);
			case (mix)
				MIX_FILL:  push_pct = 72;
				MIX_DRAIN: push_pct = 28;
				default:   push_pct = 50;
			endcase
			for (int i = 0; i < stretch && sent < num_ops; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 2) begin
					op = OP_CLEAR;
				end else if (roll < 4) begin
					op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
				end else if (roll < push_pct) begin
					op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
				end else begin
					op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
				end
				case ($urandom_range(0, 9))
					0: word = WORD_MIN;
					1: word = WORD_MAX;
					2: word = '1;
					3: word = '0;
					default: word = $urandom;
				endcase
				send_op(op, word);
				sent++;
			end
			if ($urandom_range(0, 5) == 0) begin
				wait_for_results();
			end
		end
		no_idle = 1'b0;
	endtask

	// master side: random stall before each word, none while no_idle is set
	initial begin
		int stall;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		deq_result_t want;
		logic signed [WORD_W-1:0] got_value;
		logic [OCC_W-1:0]         got_occ;
		logic [2:0]               got_pad;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_value = m_axis_tdata[31:0];
			got_occ   = m_axis_tdata[36:32];
			got_pad   = m_axis_tdata[39:37];
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected result word: value %0d status %0d occupancy %0d",
						got_value, m_axis_tuser, got_occ);
				end
			end else begin
				want = pending_results.pop_front();
				if (got_value !== want.value || m_axis_tuser !== want.status ||
						got_occ !== want.occupancy || got_pad !== '0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch: expected value %0d status %0d occupancy %0d",
							want.value, want.status, want.occupancy);
						$display("          got value %0d status %0d occupancy %0d pad %0b",
							got_value, m_axis_tuser, got_occ, got_pad);
					end
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_full_queue();
		test_random_traffic(430);
		wait_for_results();
		// room for any stray word after the last expected one
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
